// File: hw/rtl/cda_pkg.sv
package cda_pkg;

  localparam int unsigned MAX_YEAR_DEF = 9999;

  // Command codes.
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_DAYS   = 2'd1;
  localparam logic [1:0] OP_MONTHS = 2'd2;
  localparam logic [1:0] OP_YEARS  = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_LOAD = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  // Divisibility by 25 of a 12-bit value: multiply by the inverse of 25
  // modulo 4096 and compare against floor(4095 / 25).
  localparam logic [11:0] INV25_MOD4096 = 12'd3113;
  localparam logic [11:0] DIV25_LIMIT   = 12'd163;

  // Month arithmetic: the month index is biased by a multiple of 12 so that
  // it stays positive, then divided by 12 with a reciprocal multiply.
  localparam logic signed [17:0] MON_BIAS       = 18'sd32772;
  localparam logic signed [16:0] MON_BIAS_YEARS = 17'sd2731;
  localparam logic [15:0]        RECIP12        = 16'd43691;
  localparam int unsigned        RECIP12_SHIFT  = 19;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] amount;
    logic [4:0]         load_day;
    logic [3:0]         load_month;
    logic [13:0]        load_year;
  } req_t;

  typedef struct packed {
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [13:0] out_year;
    logic [1:0]  status;
  } res_t;

endpackage

// File: hw/rtl/cda_month_len.sv
module cda_month_len
  import cda_pkg::*;
(
  input  logic [3:0]  month,
  input  logic [13:0] year,
  output logic [4:0]  len
);

  logic [11:0] inv_prod;
  logic        div25;
  logic        leap;

  // Divisible by 100 means divisible by 4 with year/4 divisible by 25;
  // the 400 exception then only needs year/4 to be a multiple of 4 as well.
  assign inv_prod = year[13:2] * INV25_MOD4096;
  assign div25    = (inv_prod <= DIV25_LIMIT);
  assign leap     = (year[1:0] == 2'b00) && (!div25 || (year[3:2] == 2'b00));

  always_comb begin
    unique case (month) inside
      4'd2: begin
        len = leap ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        len = 5'd30;
      end
      default: begin
        len = 5'd31;
      end
    endcase
  end

endmodule

// File: hw/rtl/cda_div12.sv
module cda_div12
  import cda_pkg::*;
(
  input  logic        clk,
  input  logic [16:0] dividend,
  output logic [12:0] quot_r
);

  logic [32:0] prod;

  // Exact for every dividend below 2^17 because the reciprocal is rounded up; quot_r keeps 13 bits.
  assign prod = {16'b0, dividend} * {17'b0, RECIP12};

  always_ff @(posedge clk) begin
    quot_r <= prod[RECIP12_SHIFT +: 13];
  end

endmodule

// File: hw/rtl/calendar_date_adder_unit.sv
// After acceptance, load runs the range check, add years the clamp, add months the
// divider, fix-up and clamp, add days one walk step per month crossed (about 1077 for
// a full 16-bit day count), then the result state and the out_valid strobe; a negative
// day count or a year out of range skips to the result state. busy stays high until the
// strobe cycle, where a new request may already be accepted. The receiver cannot stall.
// Synchronous active-low reset sets the stored date to 1 January of year 1.
module calendar_date_adder_unit
  import cda_pkg::*;
#(
  parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  req_t in_req,
  output logic busy,
  output logic out_valid,
  output res_t out_res
);

  localparam logic [13:0]        MaxYearU = 14'(MAX_YEAR);
  localparam logic signed [16:0] MaxYearS = 17'(MAX_YEAR);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD_CHK,
    S_DAY_WALK,
    S_MON_DIV,
    S_MON_FIX,
    S_CLAMP,
    S_RESULT
  } state_t;

  state_t      state_r, state_nxt;
  logic [4:0]  cur_day_r, cur_day_nxt;
  logic [3:0]  cur_month_r, cur_month_nxt;
  logic [13:0] cur_year_r, cur_year_nxt;
  logic [15:0] wd_r, wd_nxt;
  logic [3:0]  wm_r, wm_nxt;
  logic [13:0] wy_r, wy_nxt;
  logic [16:0] wa_r, wa_nxt;
  logic [1:0]  status_r, status_nxt;
  logic        out_valid_r, out_valid_nxt;
  res_t        out_res_r, out_res_nxt;

  logic [4:0]         len;
  logic [12:0]        quot;
  logic signed [16:0] yr_sum;
  logic signed [17:0] mon_sum;
  logic [16:0]        q12;
  logic [16:0]        rem;
  logic signed [16:0] mon_year;

  cda_month_len u_month_len (
    .month (wm_r),
    .year  (wy_r),
    .len   (len)
  );

  cda_div12 u_div12 (
    .clk      (clk),
    .dividend (wa_r),
    .quot_r   (quot)
  );

  assign yr_sum   = $signed({3'b0, cur_year_r}) + 17'(in_req.amount);
  assign mon_sum  = $signed({14'b0, cur_month_r}) - 18'sd1 + 18'(in_req.amount) + MON_BIAS;
  assign q12      = {1'b0, quot, 3'b0} + {2'b0, quot, 2'b0};
  assign rem      = wa_r - q12;
  assign mon_year = $signed({3'b0, cur_year_r}) + $signed({4'b0, quot}) - MON_BIAS_YEARS;

  always_comb begin
    state_nxt     = state_r;
    cur_day_nxt   = cur_day_r;
    cur_month_nxt = cur_month_r;
    cur_year_nxt  = cur_year_r;
    wd_nxt        = wd_r;
    wm_nxt        = wm_r;
    wy_nxt        = wy_r;
    wa_nxt        = wa_r;
    status_nxt    = status_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_req.op)
            OP_LOAD: begin
              wd_nxt    = {11'b0, in_req.load_day};
              wm_nxt    = in_req.load_month;
              wy_nxt    = in_req.load_year;
              state_nxt = S_LOAD_CHK;
            end
            OP_DAYS: begin
              if (in_req.amount[15]) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_RESULT;
              end else begin
                wd_nxt    = {11'b0, cur_day_r} + 16'(in_req.amount);
                wm_nxt    = cur_month_r;
                wy_nxt    = cur_year_r;
                state_nxt = S_DAY_WALK;
              end
            end
            OP_MONTHS: begin
              wa_nxt    = mon_sum[16:0];
              state_nxt = S_MON_DIV;
            end
            OP_YEARS: begin
              if (yr_sum < 17'sd1 || yr_sum > MaxYearS) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_RESULT;
              end else begin
                wm_nxt    = cur_month_r;
                wy_nxt    = yr_sum[13:0];
                state_nxt = S_CLAMP;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_LOAD_CHK: begin
        if (wm_r >= 4'd1 && wm_r <= 4'd12 && wy_r >= 14'd1 && wy_r <= MaxYearU &&
            wd_r >= 16'd1 && wd_r <= {11'b0, len}) begin
          cur_day_nxt   = wd_r[4:0];
          cur_month_nxt = wm_r;
          cur_year_nxt  = wy_r;
          status_nxt    = ST_OK;
        end else begin
          status_nxt = ST_BAD_LOAD;
        end
        state_nxt = S_RESULT;
      end
      S_DAY_WALK: begin
        if (wd_r <= {11'b0, len}) begin
          cur_day_nxt   = wd_r[4:0];
          cur_month_nxt = wm_r;
          cur_year_nxt  = wy_r;
          status_nxt    = ST_OK;
          state_nxt     = S_RESULT;
        end else begin
          wd_nxt = wd_r - {11'b0, len};
          if (wm_r == 4'd12) begin
            wm_nxt = 4'd1;
            if (wy_r >= MaxYearU) begin
              status_nxt = ST_RANGE;
              state_nxt  = S_RESULT;
            end else begin
              wy_nxt = wy_r + 14'd1;
            end
          end else begin
            wm_nxt = wm_r + 4'd1;
          end
        end
      end
      S_MON_DIV: begin
        // The divider registers its quotient during this cycle.
        state_nxt = S_MON_FIX;
      end
      S_MON_FIX: begin
        if (mon_year < 17'sd1 || mon_year > MaxYearS) begin
          status_nxt = ST_RANGE;
          state_nxt  = S_RESULT;
        end else begin
          wm_nxt    = rem[3:0] + 4'd1;
          wy_nxt    = mon_year[13:0];
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cur_month_nxt = wm_r;
        cur_year_nxt  = wy_r;
        if (cur_day_r > len) begin
          cur_day_nxt = len;
        end
        status_nxt = ST_OK;
        state_nxt  = S_RESULT;
      end
      S_RESULT: begin
        out_valid_nxt         = 1'b1;
        out_res_nxt.out_day   = cur_day_r;
        out_res_nxt.out_month = cur_month_r;
        out_res_nxt.out_year  = cur_year_r;
        out_res_nxt.status    = status_r;
        state_nxt             = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_day_r   <= 5'd1;
      cur_month_r <= 4'd1;
      cur_year_r  <= 14'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_day_r   <= cur_day_nxt;
      cur_month_r <= cur_month_nxt;
      cur_year_r  <= cur_year_nxt;
      out_valid_r <= out_valid_nxt;
    end
    wd_r      <= wd_nxt;
    wm_r      <= wm_nxt;
    wy_r      <= wy_nxt;
    wa_r      <= wa_nxt;
    status_r  <= status_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
